### hdl/mbdlp_pkg.sv
// shared constants, register codes and lane structs for the button debounce unit
// no dependencies
package mbdlp_pkg;

  localparam int BUTTON_COUNT      = 5;
  localparam int BLINK_HALF_PERIOD = 500;

  localparam int TIME_W   = 32;
  localparam int DEB_W    = 10;
  localparam int HOLD_W   = 14;
  localparam int EVENT_W  = 4;
  localparam int TICKS_W  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (HOLD_W > BUTTON_COUNT) ? HOLD_W : BUTTON_COUNT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_ENABLED      = 3'd0,
    REG_BUTTONS_ACTIVE_LOW = 3'd1,
    REG_LEDS_ACTIVE_LOW    = 3'd2,
    REG_BUTTON_ENABLE_MASK = 3'd3,
    REG_DEBOUNCE_TIME      = 3'd4,
    REG_HOLD_TIME          = 3'd5
  } cfg_reg_t;

  localparam logic [BUTTON_COUNT-1:0] ENABLE_MASK_RESET = BUTTON_COUNT'(1);
  localparam logic [DEB_W-1:0]  DEB_RESET   = DEB_W'(50);
  localparam logic [DEB_W-1:0]  DEB_MIN     = DEB_W'(10);
  localparam logic [DEB_W-1:0]  DEB_MAX     = DEB_W'(1000);
  localparam logic [HOLD_W-1:0] HOLD_RESET  = HOLD_W'(1000);
  localparam logic [HOLD_W-1:0] HOLD_MIN    = HOLD_W'(200);
  localparam logic [HOLD_W-1:0] HOLD_MAX    = HOLD_W'(10000);

  localparam logic [EVENT_W-1:0] EVENT_CONFIGURED = EVENT_W'(0);

  // blink phase: quotient by the half period through a reciprocal multiply
  localparam int BLINK_LOG     = $clog2(BLINK_HALF_PERIOD);
  localparam int BLINK_SHIFT   = TIME_W + BLINK_LOG;
  localparam int BLINK_RECIP_W = TIME_W + 1;
  localparam int BLINK_PROD_W  = TIME_W + BLINK_RECIP_W;
  localparam logic [BLINK_RECIP_W-1:0] BLINK_RECIP = BLINK_RECIP_W'(
    ((64'd1 << BLINK_SHIFT) + 64'(BLINK_HALF_PERIOD) - 64'd1) / 64'(BLINK_HALF_PERIOD));

  typedef struct packed {
    logic clear;
    logic step;
    logic raw;
  } lane_ctrl_t;

  typedef struct packed {
    logic stable;
    logic held;
    logic press;
    logic long_hit;
  } lane_status_t;

endpackage

### hdl/mbdlp_tick_if.sv
// input channel: one tick word with timestamp and raw pin levels
// depends on mbdlp_pkg
interface mbdlp_tick_if;
  import mbdlp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       time_now;
  logic [BUTTON_COUNT-1:0] pin_levels;

  modport source (output valid, output time_now, output pin_levels, input ready);
  modport sink   (input valid, input time_now, input pin_levels, output ready);
endinterface

### hdl/mbdlp_result_if.sv
// result channel: debounced masks, pulses, led levels, event code and tick count
// depends on mbdlp_pkg
interface mbdlp_result_if;
  import mbdlp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] stable_mask;
  logic [BUTTON_COUNT-1:0] held_mask;
  logic [BUTTON_COUNT-1:0] press_pulse_mask;
  logic [BUTTON_COUNT-1:0] long_pulse_mask;
  logic                    run_led_level;
  logic                    error_led_level;
  logic [EVENT_W-1:0]      last_event_code;
  logic [TICKS_W-1:0]      tick_count;

  modport source (
    output valid, output stable_mask, output held_mask, output press_pulse_mask,
    output long_pulse_mask, output run_led_level, output error_led_level,
    output last_event_code, output tick_count, input ready
  );
  modport sink (
    input valid, input stable_mask, input held_mask, input press_pulse_mask,
    input long_pulse_mask, input run_led_level, input error_led_level,
    input last_event_code, input tick_count, output ready
  );
endinterface

### hdl/mbdlp_lane.sv
// one button lane: raw change tracking, debounce timer and long press detection
// depends on mbdlp_pkg
module mbdlp_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  mbdlp_pkg::lane_ctrl_t          ctrl,
  input  logic [mbdlp_pkg::TIME_W-1:0]   now,
  input  logic [mbdlp_pkg::DEB_W-1:0]    deb_time,
  input  logic [mbdlp_pkg::HOLD_W-1:0]   hold_time,
  output mbdlp_pkg::lane_status_t        status
);
  import mbdlp_pkg::*;

  logic              raw_seen;
  logic              stable_seen;
  logic              long_sent;
  logic              long_flag;
  logic [TIME_W-1:0] change_stamp;
  logic [TIME_W-1:0] press_stamp;

  logic [TIME_W-1:0] settle_age;
  logic [TIME_W-1:0] hold_age;
  logic raw_change;
  logic settle;
  logic press;
  logic release_hit;
  logic stable_next;
  logic long_hit;
  logic long_flag_next;
  logic long_sent_next;

  assign settle_age  = now - change_stamp;
  assign hold_age    = now - press_stamp;
  assign raw_change  = ctrl.raw != raw_seen;
  // a fresh raw change restarts the timer, so it can never settle in the same tick
  assign settle      = !raw_change && (ctrl.raw != stable_seen) &&
                       (settle_age >= TIME_W'(deb_time));
  assign press       = settle && ctrl.raw;
  assign release_hit = settle && !ctrl.raw;
  assign stable_next = settle ? ctrl.raw : stable_seen;
  // a press this tick restamps the hold timer, so no long press is taken in that tick
  assign long_hit    = stable_next && !press && !long_sent &&
                       (hold_age >= TIME_W'(hold_time));

  always_comb begin
    long_flag_next = long_flag;
    long_sent_next = long_sent;
    if (release_hit) begin
      long_flag_next = 1'b0;
    end
    if (press) begin
      long_sent_next = 1'b0;
    end
    if (long_hit) begin
      long_flag_next = 1'b1;
      long_sent_next = 1'b1;
    end
  end

  always_comb begin
    if (ctrl.step) begin
      status.stable   = stable_next;
      status.held     = long_flag_next;
      status.press    = press;
      status.long_hit = long_hit;
    end else begin
      status.stable   = stable_seen;
      status.held     = long_flag;
      status.press    = 1'b0;
      status.long_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      raw_seen     <= 1'b0;
      stable_seen  <= 1'b0;
      long_sent    <= 1'b0;
      long_flag    <= 1'b0;
      change_stamp <= '0;
      press_stamp  <= '0;
    end else if (ctrl.step) begin
      raw_seen    <= ctrl.raw;
      stable_seen <= stable_next;
      long_sent   <= long_sent_next;
      long_flag   <= long_flag_next;
      if (raw_change) begin
        change_stamp <= now;
      end
      if (press) begin
        press_stamp <= now;
      end
    end
  end

  a_press_or_long : assert property (@(posedge clk) disable iff (rst)
    !(status.press && status.long_hit))
    else $error("press and long press in one tick");

  a_held_needs_stable : assert property (@(posedge clk) disable iff (rst)
    status.held |-> status.stable)
    else $error("held without a stable press");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (!stable_seen && !long_flag && !long_sent))
    else $error("lane state survived a clear");

  a_long_once : assert property (@(posedge clk) disable iff (rst)
    (status.long_hit && !ctrl.clear) |=> long_sent)
    else $error("long press not marked as sent");

endmodule

### hdl/multi_button_debounce_long_press_unit.sv
// top level of the multi button debounce and long press unit
// depends on mbdlp_pkg, mbdlp_tick_if, mbdlp_result_if and mbdlp_lane
//
// Usage:
//   tick    : valid/ready word with a millisecond time_now and raw pin_levels
//   result  : valid/ready word with debounced, held and pulse masks, led levels,
//             the last event code and the running tick count
//   cfg_*   : plain write port, cfg_wen with cfg_index and cfg_wdata; a write to a
//             known register also clears all button state and the event code
// An accepted tick lands in the input register, and from there the result
// register is loaded through the per button lanes and the blink multiply once
// the result side can take it. One word is accepted every cycle while the
// result side keeps up.
// A stalled result holds in its register; the input register still takes one
// more word, after which ready drops until the result is taken.
// Reset clears all button state, the tick count and both valid flags, and
// loads the register defaults. Configuration must be written while idle.
module multi_button_debounce_long_press_unit (
  input  logic                              clk,
  input  logic                              rst,
  mbdlp_tick_if.sink                        tick,
  mbdlp_result_if.source                    result,
  input  logic                              cfg_wen,
  input  logic [mbdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbdlp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mbdlp_pkg::*;

  // configuration
  logic                    block_enabled;
  logic                    buttons_active_low;
  logic                    leds_active_low;
  logic [BUTTON_COUNT-1:0] button_enable_mask;
  logic [DEB_W-1:0]        debounce_time;
  logic [HOLD_W-1:0]       hold_time;
  logic                    cfg_known;
  logic                    cfg_clear;

  always_comb begin
    unique case (cfg_index)
      REG_BLOCK_ENABLED, REG_BUTTONS_ACTIVE_LOW, REG_LEDS_ACTIVE_LOW,
      REG_BUTTON_ENABLE_MASK, REG_DEBOUNCE_TIME, REG_HOLD_TIME: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  assign cfg_clear = cfg_wen && cfg_known;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enabled      <= 1'b1;
      buttons_active_low <= 1'b1;
      leds_active_low    <= 1'b0;
      button_enable_mask <= ENABLE_MASK_RESET;
      debounce_time      <= DEB_RESET;
      hold_time          <= HOLD_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BLOCK_ENABLED:      block_enabled      <= cfg_wdata[0];
        REG_BUTTONS_ACTIVE_LOW: buttons_active_low <= cfg_wdata[0];
        REG_LEDS_ACTIVE_LOW:    leds_active_low    <= cfg_wdata[0];
        REG_BUTTON_ENABLE_MASK: button_enable_mask <= cfg_wdata[BUTTON_COUNT-1:0];
        REG_DEBOUNCE_TIME:      debounce_time      <= cfg_wdata[DEB_W-1:0];
        REG_HOLD_TIME:          hold_time          <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DEB_W-1:0]  deb_eff;
  logic [HOLD_W-1:0] hold_eff;

  // out of range times fall back to their defaults
  assign deb_eff  = (debounce_time >= DEB_MIN && debounce_time <= DEB_MAX) ?
                    debounce_time : DEB_RESET;
  assign hold_eff = (hold_time >= HOLD_MIN && hold_time <= HOLD_MAX) ?
                    hold_time : HOLD_RESET;

  // input register
  logic                    s1_valid;
  logic [TIME_W-1:0]       s1_time;
  logic [BUTTON_COUNT-1:0] s1_pins;
  logic                    out_valid;
  logic                    s1_fire;

  assign s1_fire    = s1_valid && (!out_valid || result.ready);
  assign tick.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_time <= tick.time_now;
      s1_pins <= tick.pin_levels;
    end
  end

  // button lanes
  lane_ctrl_t   lane_ctrl   [BUTTON_COUNT];
  lane_status_t lane_status [BUTTON_COUNT];

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    assign lane_ctrl[i].clear = cfg_clear;
    assign lane_ctrl[i].step  = s1_fire && block_enabled && button_enable_mask[i];
    assign lane_ctrl[i].raw   = s1_pins[i] ^ buttons_active_low;

    mbdlp_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl[i]),
      .now       (s1_time),
      .deb_time  (deb_eff),
      .hold_time (hold_eff),
      .status    (lane_status[i])
    );
  end

  logic [BUTTON_COUNT-1:0] stable_next;
  logic [BUTTON_COUNT-1:0] held_next;
  logic [BUTTON_COUNT-1:0] press_next;
  logic [BUTTON_COUNT-1:0] long_next;
  logic [EVENT_W-1:0]      event_code;
  logic [EVENT_W-1:0]      event_next;

  // ascending scan, press before long press, last event wins
  always_comb begin
    event_next = event_code;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      stable_next[i] = lane_status[i].stable;
      held_next[i]   = lane_status[i].held;
      press_next[i]  = lane_status[i].press;
      long_next[i]   = lane_status[i].long_hit;
      if (lane_status[i].press) begin
        event_next = EVENT_W'(2 * i + 1);
      end
      if (lane_status[i].long_hit) begin
        event_next = EVENT_W'(2 * i + 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      event_code <= EVENT_CONFIGURED;
    end else if (s1_fire && block_enabled) begin
      event_code <= event_next;
    end
  end

  // run led phase
  logic [BLINK_PROD_W-1:0] blink_prod;
  logic                    run_on;
  logic                    run_next;

  assign blink_prod = BLINK_PROD_W'(s1_time) * BLINK_PROD_W'(BLINK_RECIP);
  assign run_on     = !blink_prod[BLINK_SHIFT];
  assign run_next   = block_enabled ? (run_on ^ leds_active_low) : leds_active_low;

  // result register
  logic [TICKS_W-1:0]      ticks_seen;
  logic [BUTTON_COUNT-1:0] stable_mask;
  logic [BUTTON_COUNT-1:0] held_mask;
  logic [BUTTON_COUNT-1:0] press_pulse_mask;
  logic [BUTTON_COUNT-1:0] long_pulse_mask;
  logic                    run_led_level;
  logic                    error_led_level;
  logic [EVENT_W-1:0]      last_event_code;
  logic [TICKS_W-1:0]      tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      ticks_seen <= '0;
    end else if (s1_fire) begin
      out_valid  <= 1'b1;
      ticks_seen <= ticks_seen + TICKS_W'(1);
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      stable_mask      <= stable_next;
      held_mask        <= held_next;
      press_pulse_mask <= press_next;
      long_pulse_mask  <= long_next;
      run_led_level    <= run_next;
      error_led_level  <= leds_active_low;
      last_event_code  <= block_enabled ? event_next : event_code;
      tick_count       <= ticks_seen + TICKS_W'(1);
    end
  end

  assign result.valid            = out_valid;
  assign result.stable_mask      = stable_mask;
  assign result.held_mask        = held_mask;
  assign result.press_pulse_mask = press_pulse_mask;
  assign result.long_pulse_mask  = long_pulse_mask;
  assign result.run_led_level    = run_led_level;
  assign result.error_led_level  = error_led_level;
  assign result.last_event_code  = last_event_code;
  assign result.tick_count       = tick_count;

endmodule

### tb/button_status_checker.sv
`timescale 1ns / 100ps
// checker for the button debounce unit: mirrors the register writes, works out each
// result word from the accepted tick words and compares the result channel field by field
// depends on mbdlp_pkg, mbdlp_tick_if and mbdlp_result_if
module button_status_checker (
  input  logic                             clk,
  input  logic                             rst,
  mbdlp_tick_if                            tick,
  mbdlp_result_if                          result,
  input  logic                             cfg_wen,
  input  logic [mbdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbdlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               mismatch_count,
  output int                               status_in_flight
);
  import mbdlp_pkg::*;

  typedef struct packed {
    logic [BUTTON_COUNT-1:0] stable;
    logic [BUTTON_COUNT-1:0] held;
    logic [BUTTON_COUNT-1:0] press;
    logic [BUTTON_COUNT-1:0] long_hit;
    logic                    run_led;
    logic                    err_led;
    logic [EVENT_W-1:0]      code;
    logic [TICKS_W-1:0]      ticks;
  } button_status_t;

  logic                    block_on;
  logic                    keys_low;
  logic                    leds_low;
  logic [BUTTON_COUNT-1:0] lane_mask;
  logic [DEB_W-1:0]        settle_cfg;
  logic [HOLD_W-1:0]       hold_cfg;

  logic [BUTTON_COUNT-1:0] raw_level;
  logic [BUTTON_COUNT-1:0] stable_level;
  logic [BUTTON_COUNT-1:0] long_done;
  logic [BUTTON_COUNT-1:0] long_shown;
  logic [TIME_W-1:0]       change_at [BUTTON_COUNT];
  logic [TIME_W-1:0]       press_at  [BUTTON_COUNT];
  logic [EVENT_W-1:0]      last_code;
  logic [TICKS_W-1:0]      tick_total;

  button_status_t button_status_q [$];
  int             mismatches;

  task automatic clear_buttons();
    raw_level    = '0;
    stable_level = '0;
    long_done    = '0;
    long_shown   = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      change_at[b] = '0;
      press_at[b]  = '0;
    end
    last_code = EVENT_CONFIGURED;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    logic hit;
    hit = 1'b1;
    case (idx)
      REG_BLOCK_ENABLED:      block_on   = data[0];
      REG_BUTTONS_ACTIVE_LOW: keys_low   = data[0];
      REG_LEDS_ACTIVE_LOW:    leds_low   = data[0];
      REG_BUTTON_ENABLE_MASK: lane_mask  = data[BUTTON_COUNT-1:0];
      REG_DEBOUNCE_TIME:      settle_cfg = data[DEB_W-1:0];
      REG_HOLD_TIME:          hold_cfg   = data[HOLD_W-1:0];
      default:                hit        = 1'b0;
    endcase
    if (hit) clear_buttons();
  endtask

  task automatic debounce_step(input logic [TIME_W-1:0] now,
                               input logic [BUTTON_COUNT-1:0] pins,
                               output button_status_t word);
    logic [BUTTON_COUNT-1:0] press_hits;
    logic [BUTTON_COUNT-1:0] long_hits;
    logic [DEB_W-1:0]        settle_ms;
    logic [HOLD_W-1:0]       hold_ms;
    logic [TIME_W-1:0]       blink_slot;
    logic [TIME_W-1:0]       elapsed;
    logic                    raw;
    logic                    run_level;
    press_hits = '0;
    long_hits  = '0;
    settle_ms  = (settle_cfg >= DEB_MIN && settle_cfg <= DEB_MAX) ? settle_cfg : DEB_RESET;
    hold_ms    = (hold_cfg >= HOLD_MIN && hold_cfg <= HOLD_MAX) ? hold_cfg : HOLD_RESET;
    tick_total = tick_total + 1'b1;
    run_level  = leds_low;
    if (block_on) begin
      blink_slot = now / BLINK_HALF_PERIOD;
      run_level  = blink_slot[0] ? leds_low : !leds_low;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        if (lane_mask[b]) begin
          raw = keys_low ? !pins[b] : pins[b];
          if (raw != raw_level[b]) begin
            raw_level[b] = raw;
            change_at[b] = now;
          end
          elapsed = now - change_at[b];
          if (raw != stable_level[b] && elapsed >= TIME_W'(settle_ms)) begin
            if (raw) begin
              stable_level[b] = 1'b1;
              press_at[b]     = now;
              long_done[b]    = 1'b0;
              press_hits[b]   = 1'b1;
              last_code       = EVENT_W'(2 * b + 1);
            end else begin
              stable_level[b] = 1'b0;
              long_shown[b]   = 1'b0;
            end
          end
          elapsed = now - press_at[b];
          if (stable_level[b] && !long_done[b] && elapsed >= TIME_W'(hold_ms)) begin
            long_done[b]  = 1'b1;
            long_shown[b] = 1'b1;
            long_hits[b]  = 1'b1;
            last_code     = EVENT_W'(2 * b + 2);
          end
        end
      end
    end
    word = '{stable_level, long_shown, press_hits, long_hits, run_level, leds_low,
             last_code, tick_total};
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    button_status_t got;
    button_status_t want;
    button_status_t fresh;
    if (rst) begin
      block_on   = 1'b1;
      keys_low   = 1'b1;
      leds_low   = 1'b0;
      lane_mask  = ENABLE_MASK_RESET;
      settle_cfg = DEB_RESET;
      hold_cfg   = HOLD_RESET;
      clear_buttons();
      tick_total = '0;
      button_status_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_wen) write_register(cfg_index, cfg_wdata);
      if (result.valid && result.ready) begin
        got = {result.stable_mask, result.held_mask, result.press_pulse_mask,
               result.long_pulse_mask, result.run_led_level, result.error_led_level,
               result.last_event_code, result.tick_count};
        if (button_status_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none outstanding, expected none, got %h",
                   $time, got);
        end else begin
          want = button_status_q.pop_front();
          check_field("stable_mask", 32'(want.stable), 32'(got.stable));
          check_field("held_mask", 32'(want.held), 32'(got.held));
          check_field("press_pulse_mask", 32'(want.press), 32'(got.press));
          check_field("long_pulse_mask", 32'(want.long_hit), 32'(got.long_hit));
          check_field("run_led_level", 32'(want.run_led), 32'(got.run_led));
          check_field("error_led_level", 32'(want.err_led), 32'(got.err_led));
          check_field("last_event_code", 32'(want.code), 32'(got.code));
          check_field("tick_count", want.ticks, got.ticks);
        end
      end
      if (tick.valid && tick.ready) begin
        debounce_step(tick.time_now, tick.pin_levels, fresh);
        button_status_q.push_back(fresh);
      end
    end
    status_in_flight <= button_status_q.size();
    mismatch_count   <= mismatches;
  end

endmodule

### tb/multi_button_debounce_long_press_unit_test.sv
`timescale 1ns / 100ps
// testbench top for the button debounce unit: clock, reset, tick stimulus, result
// back-pressure and register writes; verdict from the checker beside the block
// depends on mbdlp_pkg, both channel interfaces, the unit and button_status_checker
module multi_button_debounce_long_press_unit_test;
  import mbdlp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  hold_off_req;
  int                    recv_idle_pct = 85;
  int                    send_idle_pct;
  int                    mismatch_count;
  int                    status_in_flight;

  logic                  keys_low_now;
  int                    settle_scale;
  int                    hold_scale;

  mbdlp_tick_if   tick_ch ();
  mbdlp_result_if result_ch ();

  multi_button_debounce_long_press_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  button_status_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick_ch),
    .result           (result_ch),
    .cfg_wen          (cfg_wen),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .status_in_flight (status_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int  stall_left;
    bit  stall_used;
    stall_left = 0;
    stall_used = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !stall_used) begin
        stall_used = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic [TIME_W-1:0] now, input logic [BUTTON_COUNT-1:0] pins);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.time_now   <= now;
    tick_ch.pin_levels <= pins;
    @(negedge clk);
    while (!tick_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle_all();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle_all();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic en, input logic keys_low, input logic leds_low,
                               input logic [BUTTON_COUNT-1:0] lanes,
                               input logic [CFG_DATA_W-1:0] settle,
                               input logic [CFG_DATA_W-1:0] hold);
    write_reg(REG_BLOCK_ENABLED, CFG_DATA_W'(en));
    write_reg(REG_BUTTONS_ACTIVE_LOW, CFG_DATA_W'(keys_low));
    write_reg(REG_LEDS_ACTIVE_LOW, CFG_DATA_W'(leds_low));
    write_reg(REG_BUTTON_ENABLE_MASK, CFG_DATA_W'(lanes));
    write_reg(REG_DEBOUNCE_TIME, settle);
    write_reg(REG_HOLD_TIME, hold);
    keys_low_now = keys_low;
    settle_scale = (settle[DEB_W-1:0] >= DEB_MIN && settle[DEB_W-1:0] <= DEB_MAX) ?
                   int'(settle[DEB_W-1:0]) : int'(DEB_RESET);
    hold_scale   = (hold >= CFG_DATA_W'(HOLD_MIN) && hold <= CFG_DATA_W'(HOLD_MAX)) ?
                   int'(hold) : int'(HOLD_RESET);
  endtask

  // one setting, then press and release sequences with bounce, plus some noise
  task automatic run_segment(input int items);
    logic [TIME_W-1:0]       now;
    logic [BUTTON_COUNT-1:0] intent;
    logic [BUTTON_COUNT-1:0] pins;
    logic [CFG_DATA_W-1:0]   settle;
    logic [CFG_DATA_W-1:0]   hold;
    int                      sel;
    case ($urandom_range(4))
      0:       settle = CFG_DATA_W'(10);
      1:       settle = CFG_DATA_W'(1000);
      2:       settle = CFG_DATA_W'($urandom_range(1000, 10));
      3:       settle = CFG_DATA_W'($urandom_range(1) ? $urandom_range(9) :
                                    $urandom_range(1023, 1001));
      default: settle = CFG_DATA_W'($urandom());
    endcase
    case ($urandom_range(4))
      0:       hold = CFG_DATA_W'(200);
      1:       hold = CFG_DATA_W'(10000);
      2:       hold = CFG_DATA_W'($urandom_range(10000, 200));
      3:       hold = CFG_DATA_W'($urandom_range(1) ? $urandom_range(199) :
                                  $urandom_range(16383, 10001));
      default: hold = CFG_DATA_W'($urandom());
    endcase
    apply_setting($urandom_range(9) != 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(1) ? 5'h1F : BUTTON_COUNT'($urandom()), settle, hold);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom()));
    now    = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(20000) : $urandom();
    intent = '0;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(99);
      if (sel < 70)
        now = now + $urandom_range(settle_scale / 3 + 1);
      else if (sel < 97)
        now = now + settle_scale + $urandom_range(hold_scale / 4);
      else
        now = $urandom();
      if ($urandom_range(99) < 20) intent[$urandom_range(BUTTON_COUNT - 1)] ^= 1'b1;
      pins = keys_low_now ? ~intent : intent;
      sel  = $urandom_range(99);
      if (sel < 15)
        pins[$urandom_range(BUTTON_COUNT - 1)] ^= 1'b1;
      else if (sel < 19)
        pins = BUTTON_COUNT'($urandom());
      send_tick(now, pins);
    end
    settle_all();
  endtask

  initial begin
    logic [TIME_W-1:0] base;
    rst                <= 1'b1;
    tick_ch.valid      <= 1'b0;
    tick_ch.time_now   <= '0;
    tick_ch.pin_levels <= '0;
    cfg_wen            <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    hold_off_req       <= 1'b0;
    send_idle_pct = 37;
    keys_low_now  = 1'b1;
    settle_scale  = 50;
    hold_scale    = 1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: button 0 only, active low, press across the time wrap
    send_tick(32'd0, 5'h1F);
    send_tick(32'hFFFF_FFFF, 5'h00);
    send_tick(32'd49, 5'h00);
    send_tick(32'd1048, 5'h00);
    send_tick(32'd1049, 5'h00);
    send_tick(32'd1060, 5'h1F);
    send_tick(32'd1110, 5'h1F);

    // shortest times, all buttons at once, last event wins
    apply_setting(1'b1, 1'b0, 1'b1, 5'h1F, CFG_DATA_W'(10), CFG_DATA_W'(200));
    base = 32'h8000_0000;
    send_tick(base, 5'h1F);
    send_tick(base + 10, 5'h1F);
    send_tick(base + 210, 5'h1F);
    write_reg(REG_SPARE_A, 14'h3FFF);
    write_reg(REG_SPARE_B, 14'h0000);
    send_tick(base + 215, 5'h1F);
    send_tick(base + 220, 5'h0A);
    send_tick(base + 225, 5'h15);

    // block disabled: leds inactive, no button is processed
    write_reg(REG_BLOCK_ENABLED, 14'h0000);
    send_tick(base + 500, 5'h1F);
    send_tick(base + 1000, 5'h00);

    // out of range times fall back to the defaults
    apply_setting(1'b1, 1'b0, 1'b0, 5'h1F, CFG_DATA_W'(5), CFG_DATA_W'(100));
    send_tick(32'd1000, 5'h1F);
    send_tick(32'd1049, 5'h1F);
    send_tick(32'd1050, 5'h1F);
    send_tick(32'd2049, 5'h1F);
    send_tick(32'd2050, 5'h1F);

    // longest times
    apply_setting(1'b1, 1'b1, 1'b0, 5'h1F, CFG_DATA_W'(1000), CFG_DATA_W'(10000));
    send_tick(32'd0, 5'h00);
    send_tick(32'd1000, 5'h00);
    send_tick(32'd11000, 5'h00);
    send_tick(32'd11000, 5'h1F);
    send_tick(32'd12000, 5'h1F);
    settle_all();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct <= 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct <= 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          hold_off_req  <= 1'b1;
        end
      endcase
      repeat (4) run_segment(70);
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && status_in_flight == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
